/* rtl/core/csrm_pkg.sv */
// Shared types and constants for the CSR matrix build and lookup unit.
// Holds item and result structs, operation and status codes, size defaults.
// No dependencies.
package csrm_pkg;

	// Default store sizes
	localparam int DEF_MAX_ROWS    = 256;
	localparam int DEF_MAX_COLS    = 256;
	localparam int DEF_MAX_ENTRIES = 4096;

	// Width of the column count register
	localparam int CFG_W = 9;

	// Operation codes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_NO_ROW = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] element_value;
		logic [7:0]  lookup_row;
		logic [7:0]  lookup_col;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic        found;
		logic [1:0]  status;
		logic [12:0] entries_stored;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic respond;   // apply an item that answers at once
		logic ptr_rd;    // read the row pointers of a lookup
		logic ptr_load;  // take the pointers into the scan range
		logic scan;      // walk the entries of the row
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic row_loaded;
		logic scan_hit;
		logic scan_end;
	} dp_status_t;

endpackage

/* rtl/core/csr_matrix_build_and_lookup_unit.sv */
// Top level of the CSR matrix build and lookup unit.
// Joins csrm_ctrl and csrm_datapath; uses csrm_pkg.
//
// An item is taken when start is high and busy is low. Clear, load and the
// unused code answer at once: the result shows on result with done high in
// the next cycle, and busy stays low, so such items can follow each cycle.
// A lookup of a loaded row raises busy through the pointer read and the
// entry scan, which reads the row's entries up to and including the
// matching one (all of the row's entries when none matches) through the
// single read port of the entry memory, one entry per cycle; its result
// follows in the cycle busy falls.
// A lookup of a row not yet loaded answers like a load. done lasts one cycle
// and cannot be held off, so the receiver must take each item as it comes.
module csr_matrix_build_and_lookup_unit #(
	parameter int MAX_ROWS    = csrm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS    = csrm_pkg::DEF_MAX_COLS,
	parameter int MAX_ENTRIES = csrm_pkg::DEF_MAX_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  csrm_pkg::in_item_t          item,
	output logic                        done,
	output csrm_pkg::out_item_t         result,
	input  logic                        cfg_we,
	input  logic [csrm_pkg::CFG_W-1:0]  cfg_wdata
);
	import csrm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	// Sequence items
	csrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	// Store and scan
	csrm_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

/* rtl/core/csrm_ctrl.sv */
// Controller state machine for the CSR matrix build and lookup unit.
// Sequences lookups through pointer read and entry scan; uses csrm_pkg.
module csrm_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              operation,
	input  csrm_pkg::dp_status_t    sts,
	output csrm_pkg::dp_cmd_t       cmd,
	output logic                    busy
);
	import csrm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PTR  = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t state_q, state_nx;

	// Decide next state and commands
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (operation == OP_LOOKUP && sts.row_loaded) begin
						cmd.ptr_rd = 1'b1;
						state_nx   = S_PTR;
					end else begin
						cmd.respond = 1'b1;
					end
				end
			end
			S_PTR: begin
				cmd.ptr_load = 1'b1;
				state_nx     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit || sts.scan_end) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* rtl/core/csrm_datapath.sv */
// Datapath for the CSR matrix build and lookup unit: counters, row pointer
// memory, entry memories, scan logic and result register; uses csrm_pkg.
module csrm_datapath #(
	parameter int MAX_ROWS    = csrm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS    = csrm_pkg::DEF_MAX_COLS,
	parameter int MAX_ENTRIES = csrm_pkg::DEF_MAX_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [csrm_pkg::CFG_W-1:0]   cfg_wdata,
	input  csrm_pkg::in_item_t           item,
	input  csrm_pkg::dp_cmd_t            cmd,
	output csrm_pkg::dp_status_t         sts,
	output logic                         done,
	output csrm_pkg::out_item_t          result
);
	import csrm_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ENT_A = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RL_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EC_W  = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
	localparam int RW    = (RL_W > 8) ? RL_W : 8;
	localparam int CMP_W = (COL_W > 8) ? COL_W : 8;

	// Configuration and counters
	logic [CFG_W-1:0] columns_q;
	logic [CNT_W-1:0] count_q, count_nx;
	logic [COL_W-1:0] pos_q, pos_nx;
	logic [RL_W-1:0]  rows_q, rows_nx;

	// Memories
	logic [CNT_W-1:0] row_end_mem [MAX_ROWS+1];
	logic [COL_W-1:0] col_mem [MAX_ENTRIES];
	logic [63:0]      val_mem [MAX_ENTRIES];

	// Lookup registers
	logic [CNT_W-1:0] re_lo_s1, re_hi_s1;
	logic             row_zero_q;
	logic [7:0]       col_q;
	logic [CNT_W-1:0] idx_q, end_q;
	logic             pend_s1;
	logic [COL_W-1:0] col_rd_s1;
	logic [63:0]      val_rd_s1;

	// Result register
	out_item_t res_q, res_nx;
	logic      done_q;

	// Load decode
	logic [EC_W-1:0] eff_cols;
	logic            row_done, nonzero, rows_full, count_full;
	logic            ent_we, re_we, ent_re, hit, finish;
	logic [1:0]      status_v;
	logic [RL_W-1:0] row_a, re_wa;

	// Clamp the column count and find the end of the row
	always_comb begin
		if (columns_q == '0) begin
			eff_cols = EC_W'(1);
		end else if (EC_W'(columns_q) > EC_W'(MAX_COLS)) begin
			eff_cols = EC_W'(MAX_COLS);
		end else begin
			eff_cols = EC_W'(columns_q);
		end
	end

	assign row_done   = (EC_W'(pos_q) + EC_W'(1)) >= eff_cols;
	assign nonzero    = |item.element_value[62:0];
	assign rows_full  = (rows_q == RL_W'(MAX_ROWS));
	assign count_full = (count_q >= CNT_W'(MAX_ENTRIES));
	assign re_wa      = rows_q + RL_W'(1);
	assign row_a      = RL_W'(item.lookup_row);

	// Work out the effect of an item that answers at once
	always_comb begin
		count_nx = count_q;
		pos_nx   = pos_q;
		rows_nx  = rows_q;
		ent_we   = 1'b0;
		re_we    = 1'b0;
		status_v = STAT_OK;
		case (item.operation)
			OP_CLEAR: begin
				count_nx = '0;
				pos_nx   = '0;
				rows_nx  = '0;
			end
			OP_LOAD: begin
				if (rows_full) begin
					status_v = STAT_FULL;
				end else begin
					if (nonzero) begin
						if (count_full) begin
							status_v = STAT_FULL;
						end else begin
							ent_we   = cmd.respond;
							count_nx = count_q + CNT_W'(1);
						end
					end
					if (row_done) begin
						rows_nx = rows_q + RL_W'(1);
						re_we   = cmd.respond;
						pos_nx  = '0;
					end else begin
						pos_nx = pos_q + COL_W'(1);
					end
				end
			end
			OP_LOOKUP: begin
				status_v = STAT_NO_ROW;
			end
			default: begin
			end
		endcase
	end

	// Scan: match the previous read, issue the next one
	assign hit    = pend_s1 && (CMP_W'(col_rd_s1) == CMP_W'(col_q));
	assign ent_re = cmd.scan && !hit && (idx_q < end_q);
	assign finish = cmd.scan && (hit || (idx_q >= end_q));

	assign sts.row_loaded = RW'(item.lookup_row) < RW'(rows_q);
	assign sts.scan_hit   = hit;
	assign sts.scan_end   = (idx_q >= end_q) && !hit;

	// Select the result to register
	always_comb begin
		res_nx = '0;
		if (finish) begin
			res_nx.result_value   = hit ? val_rd_s1 : 64'd0;
			res_nx.found          = hit;
			res_nx.status         = STAT_OK;
			res_nx.entries_stored = 13'(count_q);
		end else begin
			res_nx.status         = status_v;
			res_nx.entries_stored = 13'(count_nx);
		end
	end

	// Hold configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= CFG_W'(1);
			count_q   <= '0;
			pos_q     <= '0;
			rows_q    <= '0;
			pend_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				columns_q <= cfg_wdata;
			end
			if (cmd.respond) begin
				count_q <= count_nx;
				pos_q   <= pos_nx;
				rows_q  <= rows_nx;
			end
			pend_s1 <= ent_re;
			done_q  <= cmd.respond || finish;
		end
	end

	// Hold lookup range and result payload
	always_ff @(posedge clk) begin
		if (cmd.ptr_rd) begin
			col_q      <= item.lookup_col;
			row_zero_q <= (item.lookup_row == 8'd0);
		end
		if (cmd.ptr_load) begin
			idx_q <= row_zero_q ? '0 : re_lo_s1;
			end_q <= re_hi_s1;
		end else if (ent_re) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.respond || finish) begin
			res_q <= res_nx;
		end
	end

	// Row end pointer memory
	always_ff @(posedge clk) begin
		if (re_we) begin
			row_end_mem[re_wa] <= count_nx;
		end
		if (cmd.ptr_rd) begin
			re_lo_s1 <= row_end_mem[row_a];
			re_hi_s1 <= row_end_mem[row_a + RL_W'(1)];
		end
	end

	// Entry memories
	always_ff @(posedge clk) begin
		if (ent_we) begin
			col_mem[count_q[ENT_A-1:0]] <= pos_q;
			val_mem[count_q[ENT_A-1:0]] <= item.element_value;
		end
		if (ent_re) begin
			col_rd_s1 <= col_mem[idx_q[ENT_A-1:0]];
			val_rd_s1 <= val_mem[idx_q[ENT_A-1:0]];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* rtl/core/csrm_checker.sv */
// Port checker for the CSR matrix build and lookup unit, bound to the top.
// Watches items and results over time; uses csrm_pkg.
module csrm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input csrm_pkg::in_item_t          item,
	input logic                        done,
	input csrm_pkg::out_item_t         result
);
	import csrm_pkg::*;

	// An item that answers at once shows its result in the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.operation != OP_LOOKUP |=> done && !busy)
		else $error("item without lookup gave no result next cycle");

	// A clear empties the store
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.operation == OP_CLEAR |=>
			result.entries_stored == 13'd0 && !result.found)
		else $error("clear left entries in the store");

	// A lookup either answers next cycle or holds the port busy
	a_lookup_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.operation == OP_LOOKUP |=> done || busy)
		else $error("lookup neither answered nor went busy");

	// A miss carries a zero value, a hit carries an ok status
	a_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.found ? result.status == STAT_OK : result.result_value == 64'd0))
		else $error("result value or status does not fit the found flag");

endmodule

bind csr_matrix_build_and_lookup_unit csrm_checker u_csrm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

/* bench/tb_csr_matrix_build_and_lookup_unit.sv */
// Self-checking bench for csr_matrix_build_and_lookup_unit: directed and random
// clear, load and lookup items checked against a shadow CSR store in a scoreboard.
// Depends on csrm_pkg and the RTL of the unit only.
module tb_csr_matrix_build_and_lookup_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import csrm_pkg::*;

	// Code 3 is not used by the unit, but the field allows it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int unsigned MAX_REPORTS = 100;

	// Shadow CSR store: predicts the answer of every accepted item and checks
	// the answers of the unit in order.
	class csr_lookup_scoreboard;
		logic [12:0]      row_end [0:DEF_MAX_ROWS];
		logic [7:0]       entry_col [0:DEF_MAX_ENTRIES-1];
		logic [63:0]      entry_val [0:DEF_MAX_ENTRIES-1];
		int unsigned      stored_cnt;
		int unsigned      load_pos;
		int unsigned      rows_loaded;
		logic [CFG_W-1:0] columns;
		out_item_t        answers_due[$];
		int unsigned      fail_count;

		function new();
			columns = CFG_W'(1);
			stored_cnt = 0;
			load_pos = 0;
			rows_loaded = 0;
			row_end[0] = '0;
			fail_count = 0;
		endfunction

		// Columns per row as the loader sees them: 0 acts as 1, clip at the maximum
		function int unsigned row_width();
			if (columns == 0)
				return 1;
			if (columns > DEF_MAX_COLS)
				return DEF_MAX_COLS;
			return 32'(columns);
		endfunction

		function void note_item(in_item_t it);
			out_item_t   want;
			int unsigned first;
			int unsigned last;
			int unsigned idx;
			want = '0;
			case (it.operation)
			OP_CLEAR: begin
				stored_cnt = 0;
				load_pos = 0;
				rows_loaded = 0;
				row_end[0] = '0;
			end
			OP_LOAD: begin
				if (rows_loaded >= DEF_MAX_ROWS) begin
					want.status = STAT_FULL;
				end else begin
					// Both signed zeros are skipped
					if (it.element_value[62:0] != '0) begin
						if (stored_cnt >= DEF_MAX_ENTRIES) begin
							want.status = STAT_FULL;
						end else begin
							entry_col[stored_cnt] = load_pos[7:0];
							entry_val[stored_cnt] = it.element_value;
							stored_cnt++;
						end
					end
					// Close the row once the position reaches the width
					if (load_pos + 1 >= row_width()) begin
						rows_loaded++;
						row_end[rows_loaded] = stored_cnt[12:0];
						load_pos = 0;
					end else begin
						load_pos++;
					end
				end
			end
			OP_LOOKUP: begin
				if (32'(it.lookup_row) >= rows_loaded) begin
					want.status = STAT_NO_ROW;
				end else begin
					first = 32'(row_end[it.lookup_row]);
					last = 32'(row_end[int'(it.lookup_row) + 1]);
					for (idx = first; idx < last; idx++) begin
						if (entry_col[idx] == it.lookup_col) begin
							want.result_value = entry_val[idx];
							want.found = 1'b1;
							break;
						end
					end
				end
			end
			default: ;
			endcase
			want.entries_stored = stored_cnt[12:0];
			answers_due = {answers_due, want};
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (answers_due.size() == 0) begin
				report("answer with nothing due", got.result_value, '0);
				return;
			end
			want = answers_due.pop_front();
			if (got.result_value !== want.result_value)
				report("result_value", got.result_value, want.result_value);
			if (got.found !== want.found)
				report("found", 64'(got.found), 64'(want.found));
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.entries_stored !== want.entries_stored)
				report("entries_stored", 64'(got.entries_stored),
					64'(want.entries_stored));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	in_item_t         item = '0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             busy;
	logic             done;
	out_item_t        result;

	csr_lookup_scoreboard sb;
	int unsigned          sender_idle_pct = 0;
	int unsigned          cycle_count = 0;

	csr_matrix_build_and_lookup_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every answer as it goes past; it cannot be held off
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [1:0] op, logic [63:0] val,
			logic [7:0] row, logic [7:0] col);
		in_item_t it;
		it.operation = op;
		it.element_value = val;
		it.lookup_row = row;
		it.lookup_col = col;
		return it;
	endfunction

	// Dense element: many signed zeros, some tiny patterns, the rest random
	function automatic logic [63:0] pick_element();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return 64'h0;
		if (pick < 35)
			return 64'h8000_0000_0000_0000;
		if (pick < 40)
			return {$urandom_range(0, 1) == 1, 55'h0, 8'($urandom_range(1, 255))};
		return {$urandom(), $urandom()};
	endfunction

	// Mostly loaded rows and columns within the row width, sometimes anything
	function automatic in_item_t pick_lookup();
		logic [7:0] row;
		logic [7:0] col;
		if (sb.rows_loaded > 0 && $urandom_range(0, 99) < 85)
			row = 8'($urandom_range(0, sb.rows_loaded - 1));
		else
			row = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 75)
			col = 8'($urandom_range(0, sb.row_width() - 1));
		else
			col = 8'($urandom_range(0, 255));
		return make_item(OP_LOOKUP, {$urandom(), $urandom()}, row, col);
	endfunction

	// Pause before the next item: now and then until all answers are in,
	// otherwise a short gap at the phase's idle rate
	task automatic hold_off();
		if ($urandom_range(0, 79) == 0) begin
			start <= 1'b0;
			@(posedge clk);
			while (sb.answers_due.size() != 0)
				@(posedge clk);
		end else if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the unit takes it
	task automatic send_item(in_item_t it);
		hold_off();
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(it);
	endtask

	// Stop sending and let every answer come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.answers_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_columns(logic [CFG_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.columns = value;
		cfg_we <= 1'b0;
	endtask

	task automatic directed_items();
		// Reset width of one column per row
		send_item(make_item(OP_UNUSED, '1, 8'hFF, 8'hFF));
		send_item(make_item(OP_LOOKUP, '0, 8'd0, 8'd0));
		send_item(make_item(OP_LOAD, 64'h3FF0_0000_0000_0000, 8'd0, 8'd0));
		send_item(make_item(OP_LOOKUP, '0, 8'd0, 8'd0));
		send_item(make_item(OP_LOOKUP, '0, 8'd0, 8'd255));
		set_columns(CFG_W'(3));
		// Row of negative zero, all ones, positive zero
		send_item(make_item(OP_LOAD, 64'h8000_0000_0000_0000, 8'd0, 8'd0));
		send_item(make_item(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'd0));
		send_item(make_item(OP_LOAD, 64'h0, 8'd0, 8'd0));
		send_item(make_item(OP_LOOKUP, '0, 8'd1, 8'd0));
		send_item(make_item(OP_LOOKUP, '0, 8'd1, 8'd1));
		send_item(make_item(OP_LOOKUP, '0, 8'd1, 8'd2));
		// Row of smallest patterns and infinity, all kept
		send_item(make_item(OP_LOAD, 64'h0000_0000_0000_0001, 8'd0, 8'd0));
		send_item(make_item(OP_LOAD, 64'h8000_0000_0000_0001, 8'd0, 8'd0));
		send_item(make_item(OP_LOAD, 64'h7FF0_0000_0000_0000, 8'd0, 8'd0));
		send_item(make_item(OP_LOOKUP, '0, 8'd2, 8'd2));
		send_item(make_item(OP_LOOKUP, '0, 8'd2, 8'd0));
		// Rows not yet loaded
		send_item(make_item(OP_LOOKUP, '0, 8'd3, 8'd0));
		send_item(make_item(OP_LOOKUP, '1, 8'd255, 8'd255));
		// Clear, then ask again
		send_item(make_item(OP_CLEAR, '1, 8'hFF, 8'hFF));
		send_item(make_item(OP_LOOKUP, '0, 8'd0, 8'd0));
		send_item(make_item(OP_UNUSED, '0, 8'd0, 8'd0));
		send_item(make_item(OP_LOAD, '1, 8'd0, 8'd0));
	endtask

	// Mostly runs of loads and lookups into loaded rows, with rare clears
	// and noise; ignored codes are not counted
	task automatic random_items(int unsigned count);
		int unsigned sent;
		int unsigned pick;
		int unsigned run;
		int unsigned width;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				width = sb.row_width();
				run = $urandom_range(1, width > 40 ? 40 : width);
				repeat (run) begin
					send_item(make_item(OP_LOAD, pick_element(),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
					sent++;
				end
			end else if (pick < 88) begin
				send_item(pick_lookup());
				sent++;
			end else if (pick < 91) begin
				send_item(make_item(OP_CLEAR, {$urandom(), $urandom()},
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
				sent++;
			end else if (pick < 96) begin
				send_item(make_item(OP_UNUSED, {$urandom(), $urandom()},
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
			end else begin
				send_item(make_item(OP_LOOKUP, {$urandom(), $urandom()},
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
				sent++;
			end
		end
	endtask

	// Load past the last row with one column per row
	task automatic row_limit_items();
		int unsigned n;
		send_item(make_item(OP_CLEAR, '0, 8'd0, 8'd0));
		for (n = 0; n < 270; n++) begin
			send_item(make_item(OP_LOAD, pick_element(), 8'd0, 8'd0));
			if (n % 16 == 15)
				send_item(pick_lookup());
		end
		send_item(make_item(OP_LOOKUP, '0, 8'd255, 8'd0));
		send_item(make_item(OP_LOOKUP, '0, 8'd255, 8'd1));
	endtask

	// Fill the entry store with full-width rows, then load past it
	task automatic store_full_items();
		logic [63:0] val;
		int unsigned n;
		send_item(make_item(OP_CLEAR, '0, 8'd0, 8'd0));
		n = 0;
		while (sb.stored_cnt < DEF_MAX_ENTRIES || n < 300) begin
			val = {$urandom(), $urandom()};
			if (val[62:0] == '0)
				val[0] = 1'b1;
			if ($urandom_range(0, 99) < 5)
				val = 64'h0;
			send_item(make_item(OP_LOAD, val, 8'd0, 8'd0));
			if (sb.stored_cnt >= DEF_MAX_ENTRIES)
				n++;
			if ($urandom_range(0, 199) == 0)
				send_item(pick_lookup());
		end
		repeat (20) send_item(pick_lookup());
	endtask

	initial begin
		int unsigned width_plan[8];
		int unsigned idle_plan[4];
		int unsigned p;
		width_plan = '{5, 2, 256, 0, 511, 1, 33, 300};
		idle_plan = '{0, 53, 0, 34};
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();

		// Change the width between phases without clearing, so rows often
		// end under a different width than they began with
		for (p = 0; p < 8; p++) begin
			set_columns(CFG_W'(width_plan[p]));
			sender_idle_pct = idle_plan[p % 4];
			random_items(140);
		end

		set_columns(CFG_W'(1));
		sender_idle_pct = 34;
		row_limit_items();

		set_columns(CFG_W'(256));
		sender_idle_pct = 53;
		store_full_items();

		drain();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/csrm_pkg.sv
rtl/core/csrm_ctrl.sv
rtl/core/csrm_datapath.sv
rtl/core/csr_matrix_build_and_lookup_unit.sv
rtl/core/csrm_checker.sv
bench/tb_csr_matrix_build_and_lookup_unit.sv
